// File: rtl/iurc_pkg.sv
// ----------------------------------------------------------------------------
// iurc_pkg
// Shared types, codes and symbol coverage tables for the rare-symbol
// consensus block.
// ----------------------------------------------------------------------------
package iurc_pkg;

  localparam int LETTERS = 25;
  localparam int IDX_W   = 5;
  localparam int THR_W   = 7;
  localparam int PERCENT = 100;

  localparam logic [7:0]       ASCII_A    = 8'd65;
  localparam logic [7:0]       ASCII_Y    = 8'd89;
  localparam logic [7:0]       GAP_CHAR   = 8'd45;
  localparam logic [THR_W-1:0] THR_RESET  = 7'd100;

  // request function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_GLOBAL = 2'd1;
  localparam logic [1:0] FUNC_COLUMN = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  // per-cycle update strobes broadcast to every cell
  typedef struct packed {
    logic glob;
    logic loc;
    logic clr_all;
    logic clr_loc;
  } upd_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  function automatic logic [LETTERS-1:0] letter_bit(input logic [7:0] ch);
    logic [7:0] off;
    letter_bit = '0;
    off = ch - ASCII_A;
    letter_bit[off[IDX_W-1:0]] = 1'b1;
  endfunction

  localparam logic [LETTERS-1:0] COVER_A =
    letter_bit("W") | letter_bit("R") | letter_bit("M") | letter_bit("V") |
    letter_bit("H") | letter_bit("D") | letter_bit("N");
  localparam logic [LETTERS-1:0] COVER_C =
    letter_bit("M") | letter_bit("Y") | letter_bit("S") | letter_bit("B") |
    letter_bit("V") | letter_bit("H") | letter_bit("N");
  localparam logic [LETTERS-1:0] COVER_G =
    letter_bit("R") | letter_bit("K") | letter_bit("S") | letter_bit("B") |
    letter_bit("V") | letter_bit("D") | letter_bit("N");
  localparam logic [LETTERS-1:0] COVER_T =
    letter_bit("W") | letter_bit("K") | letter_bit("Y") | letter_bit("B") |
    letter_bit("H") | letter_bit("D") | letter_bit("N");

  // letters that one symbol adds to: its own, plus ambiguity codes for bases
  function automatic logic [LETTERS-1:0] cover_mask(input logic [7:0] sym);
    logic [LETTERS-1:0] m;
    logic [7:0]         off;
    m   = '0;
    off = sym - ASCII_A;
    if (sym >= ASCII_A && sym <= ASCII_Y) begin
      m[off[IDX_W-1:0]] = 1'b1;
    end
    unique case (sym)
      "A": m = m | COVER_A;
      "C": m = m | COVER_C;
      "G": m = m | COVER_G;
      "T", "U": m = m | COVER_T;
      default: m = m;
    endcase
    cover_mask = m;
  endfunction

endpackage

// File: rtl/iurc_cell.sv
// ----------------------------------------------------------------------------
// iurc_cell
// One letter of the alphabet: global and column counters, plus one step of
// the consensus scan that passes the running best to the next cell.
// ----------------------------------------------------------------------------
module iurc_cell #(
  parameter int GLOBAL_COUNT_BITS = 32,
  parameter int COLUMN_COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  iurc_pkg::upd_t                 upd,
  input  logic                           hit,
  input  logic [COLUMN_COUNT_BITS+7:0]   thr_prod,
  input  iurc_pkg::scan_ctl_t            ctl_in,
  input  logic [GLOBAL_COUNT_BITS-1:0]   best_in,
  output iurc_pkg::scan_ctl_t            ctl_out,
  output logic [GLOBAL_COUNT_BITS-1:0]   best_out
);

  localparam int PW = COLUMN_COUNT_BITS + 8;
  localparam logic [GLOBAL_COUNT_BITS-1:0] GMAX = {GLOBAL_COUNT_BITS{1'b1}};
  localparam logic [COLUMN_COUNT_BITS-1:0] CMAX = {COLUMN_COUNT_BITS{1'b1}};

  logic [GLOBAL_COUNT_BITS-1:0] gcnt;
  logic [COLUMN_COUNT_BITS-1:0] lcnt;
  logic [PW-1:0]                lim;
  logic                         cand;
  logic                         take;

  // local >= floor(p/100)  <=>  100*(local+1) > p
  assign lim  = (PW'(lcnt) + PW'(1)) * PW'(iurc_pkg::PERCENT);
  assign cand = lim > thr_prod;
  assign take = ctl_in.valid && cand && (gcnt < best_in);

  always_ff @(posedge clk) begin
    if (rst || upd.clr_all) begin
      gcnt <= '0;
    end else if (upd.glob && hit && gcnt != GMAX) begin
      gcnt <= gcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clr_all || upd.clr_loc) begin
      lcnt <= '0;
    end else if (upd.loc && hit && lcnt != CMAX) begin
      lcnt <= lcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.found <= ctl_in.found | take;
    ctl_out.pos   <= ctl_in.pos + 1'b1;
    ctl_out.idx   <= take ? ctl_in.pos : ctl_in.idx;
    best_out      <= take ? gcnt : best_in;
  end

endmodule

// File: rtl/iupac_rare_symbol_consensus_top.sv
// ----------------------------------------------------------------------------
// iupac_rare_symbol_consensus_top
// Rare-symbol IUPAC column consensus built as a row of per-letter cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests (in_valid/in_stall) carry func, symbol and last. func
//   clear resets every counter, func global feeds the global table and the
//   total, func column feeds the column table and the row count. A column
//   request with last set closes the column and yields one result on the
//   output channel (out_valid/out_stall): the chosen letter, or '-' with
//   no_winner set. Other requests yield nothing.
//   Clear, global and column requests that do not end a column do not
//   stall the input. A column end stalls the input until its result is
//   loaded, going through these steps in order: acceptance, forming
//   row*threshold in the single multiplier, the scan token walking the
//   letter cells one per cycle, and loading the result register. The
//   result register frees the input side; a column end waits in its
//   multiplier step while a previous result is still held by a stalled
//   receiver.
//   Reset clears all counts and sets the threshold to 100 percent. The
//   threshold register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module iupac_rare_symbol_consensus_top #(
  parameter int GLOBAL_COUNT_BITS = 32,
  parameter int COLUMN_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  symbol,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  consensus,
  output logic        no_winner
);

  localparam int LETTERS = iurc_pkg::LETTERS;
  localparam int THR_W   = iurc_pkg::THR_W;
  localparam int PW      = COLUMN_COUNT_BITS + 8;
  localparam int MW      = COLUMN_COUNT_BITS + THR_W;
  localparam logic [GLOBAL_COUNT_BITS-1:0] GMAX = {GLOBAL_COUNT_BITS{1'b1}};
  localparam logic [COLUMN_COUNT_BITS-1:0] CMAX = {COLUMN_COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t                       state;
  logic [THR_W-1:0]             thr;
  logic [GLOBAL_COUNT_BITS-1:0] total;
  logic [COLUMN_COUNT_BITS-1:0] rows;
  logic [PW-1:0]                thr_prod;
  logic [MW-1:0]                prod;
  logic                         launch;
  logic                         in_acc;
  logic                         cfg_wr;
  logic                         scan_done;
  logic [LETTERS-1:0]           mask;
  logic [LETTERS-1:0]           tok_vec;
  iurc_pkg::upd_t               upd;
  iurc_pkg::scan_ctl_t          ctl  [LETTERS+1];
  logic [GLOBAL_COUNT_BITS-1:0] best [LETTERS+1];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == iurc_pkg::REG_THRESHOLD);
  assign prdata = (paddr[2] == iurc_pkg::REG_THRESHOLD) ? 32'(thr) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= iurc_pkg::THR_RESET;
    end else if (cfg_wr) begin
      thr <= pwdata[THR_W-1:0];
    end
  end

  // request side
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign mask      = iurc_pkg::cover_mask(symbol);
  assign scan_done = ctl[LETTERS].valid;

  assign upd.glob    = in_acc && (func == iurc_pkg::FUNC_GLOBAL);
  assign upd.loc     = in_acc && (func == iurc_pkg::FUNC_COLUMN);
  assign upd.clr_all = in_acc && (func == iurc_pkg::FUNC_CLEAR);
  assign upd.clr_loc = scan_done;

  always_ff @(posedge clk) begin
    if (rst || upd.clr_all) begin
      total <= '0;
    end else if (upd.glob && total != GMAX) begin
      total <= total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clr_all || upd.clr_loc) begin
      rows <= '0;
    end else if (upd.loc && rows != CMAX) begin
      rows <= rows + 1'b1;
    end
  end

  assign prod = MW'(rows) * MW'(thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (upd.loc && last) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            state  <= S_SCAN;
            launch <= 1'b1;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      thr_prod <= PW'(prod);
    end
  end

  // cell row
  assign ctl[0]  = '{valid: launch, found: 1'b0, pos: '0, idx: '0};
  assign best[0] = total;

  for (genvar g = 0; g < LETTERS; g++) begin : g_cell
    iurc_cell #(
      .GLOBAL_COUNT_BITS (GLOBAL_COUNT_BITS),
      .COLUMN_COUNT_BITS (COLUMN_COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .upd      (upd),
      .hit      (mask[g]),
      .thr_prod (thr_prod),
      .ctl_in   (ctl[g]),
      .best_in  (best[g]),
      .ctl_out  (ctl[g+1]),
      .best_out (best[g+1])
    );
    assign tok_vec[g] = ctl[g+1].valid;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_done) begin
      consensus <= ctl[LETTERS].found ?
                   (iurc_pkg::ASCII_A + 8'(ctl[LETTERS].idx)) : iurc_pkg::GAP_CHAR;
      no_winner <= !ctl[LETTERS].found;
    end
  end

  // at most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == S_SCAN)
    else $error("scan token left the row outside a scan");

  a_launch_from_mul: assert property (@(posedge clk) disable iff (rst)
    launch |-> $past(state) == S_MUL)
    else $error("scan launched without a product stage");

  a_out_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(scan_done))
    else $error("result appeared without a finished scan");

  a_gap_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_winner |-> consensus == iurc_pkg::GAP_CHAR)
    else $error("gap result without the gap character");

endmodule
